[rtl/sps_pkg.sv]
// Shared types, register codes and the sine table function of the sine PWM test sequencer.
package sps_pkg;

    localparam int AMP_W   = 13;
    localparam int STEP_W  = 24;
    localparam int CNT_W   = 24;
    localparam int FAULT_W = 16;
    localparam int MIN_W   = 12;
    localparam int MAG_W   = 15;
    localparam int DUTY_W  = 13;

    localparam logic [CNT_W-1:0] BRAKE_RESET = 24'd1000;

    // configuration register indexes
    localparam logic [2:0] REG_AMPLITUDE   = 3'd0;
    localparam logic [2:0] REG_PHASE_STEP  = 3'd1;
    localparam logic [2:0] REG_BRAKE_TICKS = 3'd2;
    localparam logic [2:0] REG_CONST_MODE  = 3'd3;
    localparam logic [2:0] REG_MIN_DUTY    = 3'd4;

    // event kinds
    localparam logic [1:0] MODE_START = 2'd0;
    localparam logic [1:0] MODE_TICK  = 2'd1;
    localparam logic [1:0] MODE_STOP  = 2'd2;

    // stop reasons
    localparam logic [1:0] STOP_OPERATOR = 2'd0;
    localparam logic [1:0] STOP_INTERNAL = 2'd1;

    typedef enum logic [1:0] {
        RUN_IDLE  = 2'd0,
        RUN_PLATE = 2'd1,
        RUN_BRAKE = 2'd2
    } run_t;

    // how the duty register is updated by an event
    typedef enum logic [1:0] {
        SRC_HOLD = 2'd0,
        SRC_ZERO = 2'd1,
        SRC_CALC = 2'd2
    } duty_src_t;

    typedef struct packed {
        logic                   op_stop;
        logic [FAULT_W-1:0]     fault;
        logic                   done;
        run_t                   run_state;
        logic                   pwm_on;
    } status_t;

    typedef struct packed {
        logic signed [AMP_W-1:0] amplitude;
        logic [STEP_W-1:0]       phase_step;
        logic [CNT_W-1:0]        brake_ticks;
        logic                    const_mode;
        logic [MIN_W-1:0]        min_safe_duty;
    } cfg_t;

    // Q15 magnitude of the sine at quarter-wave position r, 9th-order odd polynomial
    // with Q30 coefficients; evaluated at elaboration only.
    function automatic logic [MAG_W-1:0] sine_mag(input int unsigned r, input int unsigned abits);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] p;
        logic [63:0] y;
        logic [63:0] v;
        x  = 64'(r) << (32 - abits);
        x2 = (x * x) >> 30;
        p  = 64'd172272;
        p  = 64'd5026995    - ((x2 * p) >> 30);
        p  = 64'd85569306   - ((x2 * p) >> 30);
        p  = 64'd693598668  - ((x2 * p) >> 30);
        p  = 64'd1686629713 - ((x2 * p) >> 30);
        y  = (x * p) >> 30;
        v  = (y + 64'd16384) >> 15;
        if (v > 64'd32767)
        begin
            v = 64'd32767;
        end
        return v[MAG_W-1:0];
    endfunction

endpackage

[rtl/sine_pwm_test_sequencer.sv]
// Top level of the sine PWM test sequencer: configuration registers, stage flow control, ports.
//
//  channel  | direction | payload
//  ---------+-----------+-------------------------------------------------------------
//  s_*      | in        | tuser: mode; tdata: stop_kind, fault_code
//  m_*      | out       | tdata: duty, pwm_on, run_state, test_done, fault_out, op. stop
//  cfg_*    | in        | write enable, register index, write data
//
// Four-stage pipeline: sequencer/phase, sine table read, amplitude multiply, shaping and
// result register. One transfer per cycle while m_tready does not hold the output back.
// Each stage moves when the stage after it is empty or moving, so bubbles collapse and
// input is still taken while a result waits on m_tready, as long as some stage is empty.
// Reset clears all sequencer state; brake_ticks resets to 1000, other registers to 0.
module sine_pwm_test_sequencer #(
    parameter int SINE_ADDR_BITS = 10,
    parameter int PHASE_BITS     = 24,
    parameter int DUTY_BITS      = 12
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // [1:0] stop_kind, [17:2] fault_code
    input  logic [1:0]  s_tuser,   // [1:0] mode
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // [12:0] duty, [13] pwm_on, [15:14] run_state,
                                   // [16] test_done, [32:17] fault_out, [33] operator_stopped
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [23:0] cfg_data
);

    sps_pkg::cfg_t cfg_reg;

    logic en_a, en_b, en_c, en_d;
    logic a_valid, b_valid, d_valid;

    sps_pkg::duty_src_t             a_src, b_src;
    logic                           a_neg, b_neg;
    logic [SINE_ADDR_BITS-2:0]      a_r;
    logic [sps_pkg::MAG_W-1:0]      b_mag;
    sps_pkg::status_t               a_stat, b_stat, d_stat;
    logic [sps_pkg::DUTY_W-1:0]     duty;
    logic                           c_busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.amplitude     <= '0;
            cfg_reg.phase_step    <= '0;
            cfg_reg.brake_ticks   <= sps_pkg::BRAKE_RESET;
            cfg_reg.const_mode    <= 1'b0;
            cfg_reg.min_safe_duty <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                sps_pkg::REG_AMPLITUDE:   cfg_reg.amplitude     <= cfg_data[sps_pkg::AMP_W-1:0];
                sps_pkg::REG_PHASE_STEP:  cfg_reg.phase_step    <= cfg_data;
                sps_pkg::REG_BRAKE_TICKS: cfg_reg.brake_ticks   <= cfg_data;
                sps_pkg::REG_CONST_MODE:  cfg_reg.const_mode    <= cfg_data[0];
                sps_pkg::REG_MIN_DUTY:    cfg_reg.min_safe_duty <= cfg_data[sps_pkg::MIN_W-1:0];
                default:                  cfg_reg.const_mode    <= cfg_reg.const_mode;
            endcase
        end
    end

    // stage C valid tracked here for flow control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c_busy <= 1'b0;
        end
        else if (en_c)
        begin
            c_busy <= b_valid;
        end
    end

    assign en_d     = !d_valid || m_tready;
    assign en_c     = !c_busy  || en_d;
    assign en_b     = !b_valid || en_c;
    assign en_a     = !a_valid || en_b;
    assign s_tready = en_a;

    sps_ctrl #(
        .PHASE_BITS     (PHASE_BITS),
        .SINE_ADDR_BITS (SINE_ADDR_BITS)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .en         (en_a),
        .in_valid   (s_tvalid),
        .mode       (s_tuser),
        .stop_kind  (s_tdata[1:0]),
        .fault_code (s_tdata[17:2]),
        .a_valid    (a_valid),
        .a_src      (a_src),
        .a_neg      (a_neg),
        .a_r        (a_r),
        .a_stat     (a_stat)
    );

    sps_sine_rom #(
        .SINE_ADDR_BITS (SINE_ADDR_BITS)
    ) u_rom (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en_b),
        .a_valid (a_valid),
        .a_src   (a_src),
        .a_neg   (a_neg),
        .a_r     (a_r),
        .a_stat  (a_stat),
        .b_valid (b_valid),
        .b_src   (b_src),
        .b_neg   (b_neg),
        .b_mag   (b_mag),
        .b_stat  (b_stat)
    );

    sps_duty #(
        .DUTY_BITS (DUTY_BITS)
    ) u_duty (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg_reg),
        .en_c    (en_c),
        .en_d    (en_d),
        .b_valid (b_valid),
        .b_src   (b_src),
        .b_neg   (b_neg),
        .b_mag   (b_mag),
        .b_stat  (b_stat),
        .d_valid (d_valid),
        .duty    (duty),
        .d_stat  (d_stat)
    );

    assign m_tvalid = d_valid;
    assign m_tdata  = {6'b0, d_stat.op_stop, d_stat.fault, d_stat.done,
                       d_stat.run_state, d_stat.pwm_on, duty};

endmodule

[rtl/sps_ctrl.sv]
// Event sequencer: phase accumulator, brake counter, status and the first pipeline stage.
module sps_ctrl #(
    parameter int PHASE_BITS     = 24,
    parameter int SINE_ADDR_BITS = 10
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  sps_pkg::cfg_t                 cfg,
    input  logic                          en,
    input  logic                          in_valid,
    input  logic [1:0]                    mode,
    input  logic [1:0]                    stop_kind,
    input  logic [sps_pkg::FAULT_W-1:0]   fault_code,
    output logic                          a_valid,
    output sps_pkg::duty_src_t            a_src,
    output logic                          a_neg,
    output logic [SINE_ADDR_BITS-2:0]     a_r,
    output sps_pkg::status_t              a_stat
);

    localparam int QB = SINE_ADDR_BITS - 2;

    logic [PHASE_BITS-1:0]        phase_reg, phase_next, phase_sum;
    logic [sps_pkg::CNT_W-1:0]    count_reg, count_next, count_inc;
    sps_pkg::run_t                state_reg, state_next;
    logic [sps_pkg::FAULT_W-1:0]  fault_reg, fault_next;
    logic                         stop_reg, stop_next;
    logic                         pwm_reg, pwm_next;
    logic                         done;
    sps_pkg::duty_src_t           src;
    logic [SINE_ADDR_BITS-1:0]    idx;
    logic [QB-1:0]                rr;
    logic [SINE_ADDR_BITS-2:0]    r_q;

    logic                         a_valid_reg;
    sps_pkg::duty_src_t           a_src_reg;
    logic                         a_neg_reg;
    logic [SINE_ADDR_BITS-2:0]    a_r_reg;
    sps_pkg::status_t             a_stat_reg;

    always_comb
    begin
        phase_sum  = phase_reg + PHASE_BITS'(cfg.phase_step);
        count_inc  = count_reg + 1'b1;
        phase_next = phase_reg;
        count_next = count_reg;
        state_next = state_reg;
        fault_next = fault_reg;
        stop_next  = stop_reg;
        pwm_next   = pwm_reg;
        done       = 1'b0;
        src        = sps_pkg::SRC_HOLD;
        unique case (mode)
            sps_pkg::MODE_START:
            begin
                fault_next = '0;
                stop_next  = 1'b0;
                phase_next = '0;
                pwm_next   = 1'b1;
                state_next = sps_pkg::RUN_PLATE;
                src        = sps_pkg::SRC_ZERO;
            end
            sps_pkg::MODE_STOP:
            begin
                if (stop_kind == sps_pkg::STOP_OPERATOR)
                begin
                    stop_next = 1'b1;
                end
                else if (stop_kind != sps_pkg::STOP_INTERNAL)
                begin
                    fault_next = fault_code;
                end
                pwm_next   = 1'b0;
                count_next = '0;
                state_next = sps_pkg::RUN_BRAKE;
                src        = sps_pkg::SRC_ZERO;
            end
            sps_pkg::MODE_TICK:
            begin
                if (state_reg == sps_pkg::RUN_PLATE)
                begin
                    phase_next = phase_sum;
                    src        = sps_pkg::SRC_CALC;
                end
                else if (state_reg == sps_pkg::RUN_BRAKE)
                begin
                    count_next = count_inc;
                    if (count_inc >= cfg.brake_ticks)
                    begin
                        done       = 1'b1;
                        state_next = sps_pkg::RUN_IDLE;
                    end
                end
            end
            default:
            begin
                src = sps_pkg::SRC_HOLD;
            end
        endcase

        // quarter-wave fold: odd quadrants read the table mirrored
        idx = phase_sum[PHASE_BITS-1 -: SINE_ADDR_BITS];
        rr  = idx[QB-1:0];
        if (idx[QB])
        begin
            r_q = {1'b1, {QB{1'b0}}} - {1'b0, rr};
        end
        else
        begin
            r_q = {1'b0, rr};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= '0;
            count_reg   <= '0;
            state_reg   <= sps_pkg::RUN_IDLE;
            fault_reg   <= '0;
            stop_reg    <= 1'b0;
            pwm_reg     <= 1'b0;
            a_valid_reg <= 1'b0;
        end
        else
        begin
            if (en && in_valid)
            begin
                phase_reg <= phase_next;
                count_reg <= count_next;
                state_reg <= state_next;
                fault_reg <= fault_next;
                stop_reg  <= stop_next;
                pwm_reg   <= pwm_next;
            end
            if (en)
            begin
                a_valid_reg <= in_valid;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_src_reg  <= src;
            a_neg_reg  <= idx[SINE_ADDR_BITS-1];
            a_r_reg    <= r_q;
            a_stat_reg <= '{op_stop: stop_next, fault: fault_next, done: done,
                            run_state: state_next, pwm_on: pwm_next};
        end
    end

    assign a_valid = a_valid_reg;
    assign a_src   = a_src_reg;
    assign a_neg   = a_neg_reg;
    assign a_r     = a_r_reg;
    assign a_stat  = a_stat_reg;

endmodule

[rtl/sps_sine_rom.sv]
// Quarter-wave Q15 sine table with registered read, second pipeline stage.
module sps_sine_rom #(
    parameter int SINE_ADDR_BITS = 10
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          en,
    input  logic                          a_valid,
    input  sps_pkg::duty_src_t            a_src,
    input  logic                          a_neg,
    input  logic [SINE_ADDR_BITS-2:0]     a_r,
    input  sps_pkg::status_t              a_stat,
    output logic                          b_valid,
    output sps_pkg::duty_src_t            b_src,
    output logic                          b_neg,
    output logic [sps_pkg::MAG_W-1:0]     b_mag,
    output sps_pkg::status_t              b_stat
);

    localparam int QN = (1 << (SINE_ADDR_BITS - 2)) + 1;

    logic [sps_pkg::MAG_W-1:0] rom [QN];

    for (genvar gi = 0; gi < QN; gi++)
    begin : g_rom
        localparam logic [sps_pkg::MAG_W-1:0] VAL = sps_pkg::sine_mag(gi, SINE_ADDR_BITS);
        assign rom[gi] = VAL;
    end

    logic                      b_valid_reg;
    sps_pkg::duty_src_t        b_src_reg;
    logic                      b_neg_reg;
    logic [sps_pkg::MAG_W-1:0] b_mag_reg;
    sps_pkg::status_t          b_stat_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            b_valid_reg <= a_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            b_src_reg  <= a_src;
            b_neg_reg  <= a_neg;
            b_mag_reg  <= rom[a_r];
            b_stat_reg <= a_stat;
        end
    end

    assign b_valid = b_valid_reg;
    assign b_src   = b_src_reg;
    assign b_neg   = b_neg_reg;
    assign b_mag   = b_mag_reg;
    assign b_stat  = b_stat_reg;

endmodule

[rtl/sps_duty.sv]
// Amplitude multiply, then floor, deadband shaping, clamp and the duty/result register.
module sps_duty #(
    parameter int DUTY_BITS = 12
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  sps_pkg::cfg_t                 cfg,
    input  logic                          en_c,
    input  logic                          en_d,
    input  logic                          b_valid,
    input  sps_pkg::duty_src_t            b_src,
    input  logic                          b_neg,
    input  logic [sps_pkg::MAG_W-1:0]     b_mag,
    input  sps_pkg::status_t              b_stat,
    output logic                          d_valid,
    output logic [sps_pkg::DUTY_W-1:0]    duty,
    output sps_pkg::status_t              d_stat
);

    localparam int PW = sps_pkg::MAG_W + 1 + sps_pkg::AMP_W;
    localparam int FW = PW - 15;
    localparam int SW = (DUTY_BITS + 2 > FW) ? DUTY_BITS + 2 : FW;
    localparam logic signed [SW-1:0] LIM = SW'((1 << DUTY_BITS) - 1);

    logic signed [sps_pkg::MAG_W:0] sval;
    logic signed [PW-1:0]           prod;

    logic                  c_valid_reg;
    sps_pkg::duty_src_t    c_src_reg;
    logic signed [PW-1:0]  c_prod_reg;
    sps_pkg::status_t      c_stat_reg;

    logic signed [SW-1:0]  raw, shaped, clamped, m_s;
    logic [SW-1:0]         mag_abs, m_u, half_u;

    logic                          d_valid_reg;
    logic [sps_pkg::DUTY_W-1:0]    duty_reg, duty_next;
    sps_pkg::status_t              d_stat_reg;

    always_comb
    begin
        if (b_neg)
        begin
            sval = -$signed({1'b0, b_mag});
        end
        else
        begin
            sval = $signed({1'b0, b_mag});
        end
        prod = sval * cfg.amplitude;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c_valid_reg <= 1'b0;
        end
        else if (en_c)
        begin
            c_valid_reg <= b_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en_c)
        begin
            c_src_reg  <= b_src;
            c_prod_reg <= prod;
            c_stat_reg <= b_stat;
        end
    end

    always_comb
    begin
        // arithmetic shift by 15 floors toward minus infinity
        if (cfg.const_mode)
        begin
            raw = SW'(cfg.amplitude);
        end
        else
        begin
            raw = SW'($signed(c_prod_reg[PW-1:15]));
        end
        mag_abs = raw[SW-1] ? SW'(-raw) : SW'(raw);
        m_u     = SW'(cfg.min_safe_duty);
        half_u  = m_u >> 1;
        m_s     = $signed(m_u);
        priority if (mag_abs < half_u)
        begin
            shaped = '0;
        end
        else if (mag_abs < m_u)
        begin
            if (raw > 0)
            begin
                shaped = m_s;
            end
            else if (raw < 0)
            begin
                shaped = -m_s;
            end
            else
            begin
                shaped = '0;
            end
        end
        else
        begin
            shaped = raw;
        end
        priority if (shaped > LIM)
        begin
            clamped = LIM;
        end
        else if (shaped < -LIM)
        begin
            clamped = -LIM;
        end
        else
        begin
            clamped = shaped;
        end

        unique case (c_src_reg)
            sps_pkg::SRC_ZERO: duty_next = '0;
            sps_pkg::SRC_CALC: duty_next = clamped[sps_pkg::DUTY_W-1:0];
            default:           duty_next = duty_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            d_valid_reg <= 1'b0;
            duty_reg    <= '0;
        end
        else if (en_d)
        begin
            d_valid_reg <= c_valid_reg;
            if (c_valid_reg)
            begin
                duty_reg <= duty_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en_d && c_valid_reg)
        begin
            d_stat_reg <= c_stat_reg;
        end
    end

    assign d_valid = d_valid_reg;
    assign duty    = duty_reg;
    assign d_stat  = d_stat_reg;

endmodule
